@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fsd96 checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/fsd96_pkg.sv @@
// ----------------------------------------------------------------------------
// fsd96_pkg
// Types, constants and helpers shared by the float to decimal96 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package fsd96_pkg;

  localparam int W         = 288;
  localparam int BIN_SHIFT = 149;
  localparam int QW        = 33;

  typedef struct packed {
    logic load;
    logic scale_step;
    logic aux_from_den;
    logic aux_mul;
    logic bump;
    logic set_err;
    logic div_init;
    logic div_step;
    logic round;
    logic ovf;
    logic strip;
    logic coef_init;
    logic coef_mul;
    logic trunc;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic       early_done;
    logic       tiny;
    logic       k_neg;
    logic [5:0] k_mag;
    logic       strip_ok;
    logic       s_over;
  } dp_stat_t;

  function automatic logic [W-1:0] mul10(input logic [W-1:0] x);
    return (x << 3) + (x << 1);
  endfunction

endpackage

`default_nettype wire

@@ hdl/fsd96_dp.sv @@
// ----------------------------------------------------------------------------
// fsd96_dp
// Datapath: exact ratio build-up, restoring quotient, rounding, digit strip.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd96_dp #(
  parameter int SIG_DIGITS          = 7,
  parameter int MAX_FRACTION_DIGITS = 28
) (
  input  wire logic                 clk,
  input  wire logic [31:0]          float_bits,
  input  wire fsd96_pkg::dp_cmd_t   cmd,
  output fsd96_pkg::dp_stat_t       stat,
  output logic                      status_r,
  output logic [95:0]               coeff_r,
  output logic [4:0]                scale_r,
  output logic                      negative_r
);

  localparam int W = fsd96_pkg::W;
  localparam int QW = fsd96_pkg::QW;
  localparam logic [QW-1:0] P10 = QW'(10 ** SIG_DIGITS);
  localparam int KMIN = 1 - 28 - SIG_DIGITS;
  localparam int KTR  = -MAX_FRACTION_DIGITS;

  logic [W-1:0]        num_r, num_nxt;
  logic [W-1:0]        den_r, den_nxt;
  logic [W-1:0]        aux_r, aux_nxt;
  logic [QW-1:0]       q_r, q_nxt;
  logic signed [7:0]   k_r, k_nxt;
  logic                err_r, err_nxt;
  logic                zero_r, zero_nxt;
  logic                sign_r, sign_nxt;
  logic                status_nxt, negative_nxt;
  logic [95:0]         coeff_nxt;
  logic [4:0]          scale_nxt;

  logic [7:0]          ex;
  logic [23:0]         m;
  logic [4:0]          blen;
  logic signed [9:0]   b;
  logic signed [27:0]  b_ext;
  logic signed [27:0]  t;
  logic signed [9:0]   xe_est;
  logic [7:0]          shamt;
  logic                ge;
  logic [W-1:0]        twice;
  logic [63:0]         prod;
  logic [QW-1:0]       qd;
  logic [QW-1:0]       qd10;
  logic                coef_big;
  logic signed [7:0]   k_negv;

  always_comb begin
    ex = float_bits[30:23];
    m  = (ex == 8'd0) ? {1'b0, float_bits[22:0]} : {1'b1, float_bits[22:0]};
    blen = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (float_bits[i]) begin
        blen = 5'(i + 1);
      end
    end
    if (ex == 8'd0) begin
      b     = 10'(blen) - 10'sd150;
      shamt = 8'd0;
    end else begin
      b     = $signed({2'b00, ex}) - 10'sd127;
      shamt = ex - 8'd1;
    end
    b_ext  = 28'(b);
    t      = b_ext * 28'sd78913;
    xe_est = t[27:18];
  end

  assign ge    = num_r >= aux_r;
  assign twice = num_r << 1;
  assign prod  = 64'(q_r[QW-1:1]) * 64'h0000_0000_CCCC_CCCD;
  assign qd    = QW'(prod[63:34]);
  assign qd10  = (qd << 3) + (qd << 1);
  assign coef_big = |aux_r[W-1:96];
  assign k_negv   = -k_r;

  always_comb begin
    stat.early_done = err_r || zero_r;
    stat.tiny       = k_r < $signed(8'(KMIN));
    stat.k_neg      = k_r[7];
    stat.k_mag      = k_r[7] ? 6'(k_negv) : 6'(k_r);
    stat.strip_ok   = (q_r != '0) && (q_r == qd10);
    stat.s_over     = k_r < $signed(8'(KTR));
  end

  always_comb begin
    num_nxt      = num_r;
    den_nxt      = den_r;
    aux_nxt      = aux_r;
    q_nxt        = q_r;
    k_nxt        = k_r;
    err_nxt      = err_r;
    zero_nxt     = zero_r;
    sign_nxt     = sign_r;
    status_nxt   = status_r;
    coeff_nxt    = coeff_r;
    scale_nxt    = scale_r;
    negative_nxt = negative_r;
    if (cmd.load) begin
      sign_nxt = float_bits[31];
      num_nxt  = W'(m) << shamt;
      den_nxt  = W'(1) << fsd96_pkg::BIN_SHIFT;
      aux_nxt  = '0;
      q_nxt    = '0;
      k_nxt    = 8'(xe_est - 10'(SIG_DIGITS) + 10'sd1);
      zero_nxt = (m == 24'd0) && (ex != 8'hFF);
      err_nxt  = (ex == 8'hFF) ||
                 ((m != 24'd0) && ((b >= 10'sd96) || (xe_est < -10'sd29)));
    end
    if (cmd.scale_step) begin
      if (k_r[7]) begin
        num_nxt = fsd96_pkg::mul10(num_r);
      end else begin
        den_nxt = fsd96_pkg::mul10(den_r);
      end
    end
    if (cmd.aux_from_den) aux_nxt = den_r;
    if (cmd.aux_mul) aux_nxt = fsd96_pkg::mul10(aux_r);
    if (cmd.bump && ge) begin
      den_nxt = fsd96_pkg::mul10(den_r);
      k_nxt   = k_r + 8'sd1;
    end
    if (cmd.set_err) err_nxt = 1'b1;
    if (cmd.div_init) begin
      aux_nxt = den_r << 31;
      q_nxt   = '0;
    end
    if (cmd.div_step) begin
      if (ge) num_nxt = num_r - aux_r;
      q_nxt   = {q_r[QW-2:0], ge};
      aux_nxt = aux_r >> 1;
    end
    if (cmd.round) begin
      if ((twice > den_r) || ((twice == den_r) && q_r[0])) q_nxt = q_r + QW'(1);
    end
    if ((cmd.ovf && (q_r >= P10)) || cmd.strip || cmd.trunc) begin
      q_nxt = qd;
      k_nxt = k_r + 8'sd1;
    end
    if (cmd.coef_init) aux_nxt = W'(q_r);
    if (cmd.coef_mul) aux_nxt = fsd96_pkg::mul10(aux_r);
    if (cmd.fin) begin
      status_nxt = 1'b0;
      coeff_nxt  = '0;
      scale_nxt  = '0;
      if (err_r || (!zero_r && !k_r[7] && coef_big)) begin
        status_nxt = 1'b1;
      end else if (zero_r) begin
        status_nxt = 1'b0;
      end else if (!k_r[7]) begin
        coeff_nxt = aux_r[95:0];
      end else begin
        coeff_nxt = 96'(q_r);
        scale_nxt = 5'(k_negv);
      end
      negative_nxt = sign_r && (coeff_nxt != '0);
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    aux_r      <= aux_nxt;
    q_r        <= q_nxt;
    k_r        <= k_nxt;
    err_r      <= err_nxt;
    zero_r     <= zero_nxt;
    sign_r     <= sign_nxt;
    status_r   <= status_nxt;
    coeff_r    <= coeff_nxt;
    scale_r    <= scale_nxt;
    negative_r <= negative_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/fsd96_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsd96_ctrl
// Sequencer for the converter: steps the datapath through each phase.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd96_ctrl #(
  parameter int SIG_DIGITS = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire fsd96_pkg::dp_stat_t  stat,
  output fsd96_pkg::dp_cmd_t        cmd,
  output logic                      busy,
  output logic                      done
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SCALE = 4'd2;
  localparam logic [3:0] S_AUXM  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_TINY  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_ROUND = 4'd7;
  localparam logic [3:0] S_OVF   = 4'd8;
  localparam logic [3:0] S_STRIP = 4'd9;
  localparam logic [3:0] S_COEF  = 4'd10;
  localparam logic [3:0] S_TRUNC = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  assign busy = state_r != S_IDLE;
  assign done = state_r == S_DONE;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.early_done) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt   = stat.k_mag;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (cnt_r != 6'd0) begin
          cmd.scale_step = 1'b1;
          cnt_nxt        = cnt_r - 6'd1;
        end else begin
          cmd.aux_from_den = 1'b1;
          cnt_nxt          = 6'(SIG_DIGITS);
          state_nxt        = S_AUXM;
        end
      end
      S_AUXM: begin
        if (cnt_r != 6'd0) begin
          cmd.aux_mul = 1'b1;
          cnt_nxt     = cnt_r - 6'd1;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.bump  = 1'b1;
        state_nxt = S_TINY;
      end
      S_TINY: begin
        if (stat.tiny) begin
          cmd.set_err = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = 6'd31;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == 6'd0) begin
          state_nxt = S_ROUND;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_OVF;
      end
      S_OVF: begin
        cmd.ovf   = 1'b1;
        state_nxt = S_STRIP;
      end
      S_STRIP: begin
        if (stat.strip_ok) begin
          cmd.strip = 1'b1;
        end else if (!stat.k_neg) begin
          cmd.coef_init = 1'b1;
          cnt_nxt       = stat.k_mag;
          state_nxt     = S_COEF;
        end else begin
          state_nxt = S_TRUNC;
        end
      end
      S_COEF: begin
        if (cnt_r != 6'd0) begin
          cmd.coef_mul = 1'b1;
          cnt_nxt      = cnt_r - 6'd1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_TRUNC: begin
        if (stat.s_over) begin
          cmd.trunc = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/float_to_scaled_decimal96.sv @@
// ----------------------------------------------------------------------------
// float_to_scaled_decimal96
// Converts a single precision float to a 96-bit decimal coefficient and scale.
// ----------------------------------------------------------------------------
// Steps: load and range check, |k| scale steps, SIG_DIGITS bound multiplies, the
//   normalising compare, the 32-step quotient, rounding, overflow fix, stripped
//   digits and final steps (k = estimated decimal exponent - SIG_DIGITS + 1; final
//   steps are the coefficient multiplies or the dropped excess digits). NaN,
//   infinity, zero and out-of-range words skip to the result; too-small words stop
//   after the range compare. Throughput: one word at a time; busy stays high
//   through the result strobe, so the next word can be taken in the cycle after it.
//   Reset: synchronous active-low, returns the sequencer to idle, no strobe.
`default_nettype none

module float_to_scaled_decimal96 #(
  parameter int SIG_DIGITS          = 7,
  parameter int MAX_FRACTION_DIGITS = 28
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_float_bits,
  output logic             out_valid,
  output logic             out_status,
  output logic [31:0]      out_coeff_low,
  output logic [31:0]      out_coeff_mid,
  output logic [31:0]      out_coeff_high,
  output logic [4:0]       out_scale,
  output logic             out_negative
);

  fsd96_pkg::dp_cmd_t  cmd;
  fsd96_pkg::dp_stat_t stat;
  logic [95:0]         coeff;

  fsd96_ctrl #(
    .SIG_DIGITS (SIG_DIGITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  fsd96_dp #(
    .SIG_DIGITS          (SIG_DIGITS),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_dp (
    .clk        (clk),
    .float_bits (in_float_bits),
    .cmd        (cmd),
    .stat       (stat),
    .status_r   (out_status),
    .coeff_r    (coeff),
    .scale_r    (out_scale),
    .negative_r (out_negative)
  );

  assign out_coeff_low  = coeff[31:0];
  assign out_coeff_mid  = coeff[63:32];
  assign out_coeff_high = coeff[95:64];

endmodule

`default_nettype wire

@@ hdl/fsd96_checker.sv @@
// ----------------------------------------------------------------------------
// fsd96_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fsd96_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [31:0] in_float_bits,
  input wire logic        out_valid,
  input wire logic        out_status,
  input wire logic [31:0] out_coeff_low,
  input wire logic [31:0] out_coeff_mid,
  input wire logic [31:0] out_coeff_high,
  input wire logic [4:0]  out_scale,
  input wire logic        out_negative
);

  logic coeff_zero;
  logic err_clear;

  assign coeff_zero = (out_coeff_low == 32'd0) && (out_coeff_mid == 32'd0) &&
                      (out_coeff_high == 32'd0);
  assign err_clear  = coeff_zero && (out_scale == 5'd0) && !out_negative;

  `FSD_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word not busy")
  `FSD_ASSERT_NOW(a_valid_busy, clk, rst_n, out_valid, busy, "strobe while idle")
  `FSD_ASSERT_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid && !busy, "strobe not single")
  `FSD_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_status, err_clear, "error word not cleared")
  `FSD_ASSERT_NOW(a_neg_nonzero, clk, rst_n, out_valid && out_negative, !coeff_zero, "negative zero")

endmodule

bind float_to_scaled_decimal96 fsd96_checker u_fsd96_checker (.*);

`default_nettype wire
